// ----- hw/rtl/ictu_pkg.sv -----
// Shared types, register map and helpers of the interval and compare timer unit.
package ictu_pkg;

	localparam int INTERVAL_CHANNELS_DEF = 2;
	localparam int UP_CHANNELS_DEF       = 2;
	localparam int COMPARES_PER_UP_DEF   = 4;

	localparam int DATA_W  = 32;
	localparam int DIV_W   = 8;
	localparam int TRIG_W  = 16;
	localparam int CMP_BITS = 8;
	localparam int CMP_SLOT = 4;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_WRITE = 2'd2
	} action_t;

	localparam logic [1:0] GRP_IVL  = 2'd0;
	localparam logic [1:0] GRP_FREE = 2'd1;
	localparam logic [1:0] GRP_UP   = 2'd2;

	localparam logic [5:0] REG_IVL_START   = 6'd0;
	localparam logic [5:0] REG_IVL_RESTART = 6'd1;
	localparam logic [5:0] REG_IVL_STOP    = 6'd2;
	localparam logic [5:0] REG_IVL_RUN     = 6'd3;
	localparam logic [5:0] REG_IVL_EN      = 6'd4;
	localparam logic [5:0] REG_IVL_FLAGS   = 6'd5;
	localparam logic [5:0] REG_IVL_DIV     = 6'd6;
	localparam logic [5:0] REG_FREE_START  = 6'd7;
	localparam logic [5:0] REG_FREE_RESTART = 6'd8;
	localparam logic [5:0] REG_FREE_STOP   = 6'd9;
	localparam logic [5:0] REG_FREE_RUN    = 6'd10;
	localparam logic [5:0] REG_FREE_DIV    = 6'd11;
	localparam logic [5:0] REG_UP_START    = 6'd12;
	localparam logic [5:0] REG_UP_RESTART  = 6'd13;
	localparam logic [5:0] REG_UP_STOP     = 6'd14;
	localparam logic [5:0] REG_UP_RUN      = 6'd15;
	localparam logic [5:0] REG_CMP_EN      = 6'd16;
	localparam logic [5:0] REG_CMP_FLAGS   = 6'd17;
	localparam logic [5:0] REG_UP_DIV      = 6'd18;
	localparam logic [5:0] REG_TRIG        = 6'd19;
	localparam logic [5:0] REG_GATE        = 6'd20;
	localparam logic [5:0] REG_IVL_CNT0    = 6'd21;
	localparam logic [5:0] REG_FREE_CNT    = 6'd25;
	localparam logic [5:0] REG_UP_CNT0     = 6'd26;
	localparam logic [5:0] REG_CMP_VAL0    = 6'd28;

	typedef struct packed {
		logic [1:0]  action;
		logic [5:0]  reg_index;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        interval_irq;
		logic [7:0]  compare_irq;
	} rsp_t;

	typedef struct packed {
		logic             step;
		logic [DIV_W-1:0] cnt;
	} presc_t;

	// One prescaler tick: a divider of d gives a step every d+1 ticks.
	function automatic presc_t presc_tick(input logic [DIV_W-1:0] dv,
			input logic [DIV_W-1:0] pr);
		presc_t r;
		logic [DIV_W:0] nxt;
		nxt = {1'b0, pr} + 1'b1;
		if (dv == '0) begin
			r.step = 1'b1;
			r.cnt  = pr;
		end else if (nxt > {1'b0, dv}) begin
			r.step = 1'b1;
			r.cnt  = '0;
		end else begin
			r.step = 1'b0;
			r.cnt  = nxt[DIV_W-1:0];
		end
		return r;
	endfunction

	// Compare bits are kept packed as 4*timer+compare; the register layout is 8*timer+compare.
	function automatic logic [DATA_W-1:0] cmp_to_reg(input logic [CMP_BITS-1:0] b);
		return {20'd0, b[7:4], 4'd0, b[3:0]};
	endfunction

endpackage

// ----- hw/rtl/interval_and_compare_timer_unit.sv -----
// Top level of the interval and compare timer unit: registers, tick logic and handshake.
//
// Items arrive on the req channel (valid/ready) and each one gives exactly one item
// on the rsp channel. An item is a clock tick, a register read or a register write.
// An accepted item is held in an input register; at the first later clock edge at
// which the output register is free or being taken, it is applied to the timer state
// and its result is written to the output register, which raises rsp_valid.
// One item is accepted every cycle as long as the output side keeps up. The tick
// and register logic is combinational between the input and output registers. When
// the receiver stalls, the finished result waits in the output register and the
// input register holds one more item, after which req_ready falls until the
// receiver takes the waiting result.
// Reset clears all timer state, flags, dividers and prescalers to zero and
// empties both registers; req_ready is high from the first cycle after reset.
// Register numbers follow the register map in ictu_pkg; flag bits are cleared by writing
// zero to them, and in gating mode a compare interrupt is raised only while no compare flag is set.
module interval_and_compare_timer_unit #(
	parameter int INTERVAL_CHANNELS = ictu_pkg::INTERVAL_CHANNELS_DEF,
	parameter int UP_CHANNELS       = ictu_pkg::UP_CHANNELS_DEF,
	parameter int COMPARES_PER_UP   = ictu_pkg::COMPARES_PER_UP_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ictu_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ictu_pkg::rsp_t rsp
);

	localparam int IC = INTERVAL_CHANNELS;
	localparam int UC = UP_CHANNELS;
	localparam int CC = COMPARES_PER_UP;
	localparam int DW = ictu_pkg::DATA_W;
	localparam int VW = ictu_pkg::DIV_W;
	localparam int CB = ictu_pkg::CMP_BITS;

	ictu_pkg::req_t req_s1;
	logic           valid_s1;
	ictu_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;
	logic           adv;
	logic           proc;

	logic [IC-1:0]       ivl_run_q, ivl_run_d;
	logic [IC-1:0]       ivl_en_q, ivl_en_d;
	logic [IC-1:0]       ivl_flag_q, ivl_flag_d;
	logic [DW-1:0]       ivl_cnt_q [IC];
	logic [DW-1:0]       ivl_cnt_d [IC];
	logic [DW-1:0]       ivl_rld_q [IC];
	logic [DW-1:0]       ivl_rld_d [IC];
	logic [VW-1:0]       div_q [3];
	logic [VW-1:0]       div_d [3];
	logic [VW-1:0]       pre_q [3];
	logic [VW-1:0]       pre_d [3];
	logic                free_run_q, free_run_d;
	logic [DW-1:0]       free_cnt_q, free_cnt_d;
	logic [UC-1:0]       up_run_q, up_run_d;
	logic [DW-1:0]       up_cnt_q [UC];
	logic [DW-1:0]       up_cnt_d [UC];
	logic [DW-1:0]       cmp_val_q [UC][CC];
	logic [DW-1:0]       cmp_val_d [UC][CC];
	logic [CB-1:0]       cmp_en_q, cmp_en_d;
	logic [CB-1:0]       cmp_flag_q, cmp_flag_d;
	logic [ictu_pkg::TRIG_W-1:0] trig_q, trig_d;
	logic                gate_q, gate_d;
	ictu_pkg::rsp_t      rsp_d;

	assign adv       = !rsp_valid_q || rsp_ready;
	assign proc      = valid_s1 && adv;
	assign req_ready = !valid_s1 || adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			valid_s1 <= (req_valid && req_ready) || (valid_s1 && !adv);
			if (proc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (proc) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ivl_run_q  <= '0;
			ivl_en_q   <= '0;
			ivl_flag_q <= '0;
			for (int m = 0; m < IC; m++) begin
				ivl_cnt_q[m] <= '0;
				ivl_rld_q[m] <= '0;
			end
			for (int g = 0; g < 3; g++) begin
				div_q[g] <= '0;
				pre_q[g] <= '0;
			end
			free_run_q <= 1'b0;
			free_cnt_q <= '0;
			up_run_q   <= '0;
			for (int m = 0; m < UC; m++) begin
				up_cnt_q[m] <= '0;
				for (int i = 0; i < CC; i++) begin
					cmp_val_q[m][i] <= '0;
				end
			end
			cmp_en_q   <= '0;
			cmp_flag_q <= '0;
			trig_q     <= '0;
			gate_q     <= 1'b0;
		end else if (proc) begin
			ivl_run_q  <= ivl_run_d;
			ivl_en_q   <= ivl_en_d;
			ivl_flag_q <= ivl_flag_d;
			ivl_cnt_q  <= ivl_cnt_d;
			ivl_rld_q  <= ivl_rld_d;
			div_q      <= div_d;
			pre_q      <= pre_d;
			free_run_q <= free_run_d;
			free_cnt_q <= free_cnt_d;
			up_run_q   <= up_run_d;
			up_cnt_q   <= up_cnt_d;
			cmp_val_q  <= cmp_val_d;
			cmp_en_q   <= cmp_en_d;
			cmp_flag_q <= cmp_flag_d;
			trig_q     <= trig_d;
			gate_q     <= gate_d;
		end
	end

	always_comb begin
		ictu_pkg::presc_t ps;
		logic [5:0]       idx;
		logic [DW-1:0]    v;
		logic [DW-1:0]    cnt;
		ivl_run_d  = ivl_run_q;
		ivl_en_d   = ivl_en_q;
		ivl_flag_d = ivl_flag_q;
		ivl_cnt_d  = ivl_cnt_q;
		ivl_rld_d  = ivl_rld_q;
		div_d      = div_q;
		pre_d      = pre_q;
		free_run_d = free_run_q;
		free_cnt_d = free_cnt_q;
		up_run_d   = up_run_q;
		up_cnt_d   = up_cnt_q;
		cmp_val_d  = cmp_val_q;
		cmp_en_d   = cmp_en_q;
		cmp_flag_d = cmp_flag_q;
		trig_d     = trig_q;
		gate_d     = gate_q;
		rsp_d      = '0;
		ps         = '0;
		cnt        = '0;
		idx        = req_s1.reg_index;
		v          = req_s1.write_data;
		case (req_s1.action)
			ictu_pkg::ACT_TICK: begin
				if (ivl_run_q != '0) begin
					ps = ictu_pkg::presc_tick(div_q[ictu_pkg::GRP_IVL],
						pre_q[ictu_pkg::GRP_IVL]);
					pre_d[ictu_pkg::GRP_IVL] = ps.cnt;
					for (int m = 0; m < IC; m++) begin
						if (ivl_run_q[m] && ps.step) begin
							if (ivl_cnt_q[m] == '0) begin
								ivl_flag_d[m] = 1'b1;
								ivl_cnt_d[m]  = ivl_rld_q[m];
							end else begin
								ivl_cnt_d[m] = ivl_cnt_q[m] - 1'b1;
							end
						end
					end
					rsp_d.interval_irq = |(ivl_flag_d & ivl_en_q);
				end
				if (free_run_q) begin
					ps = ictu_pkg::presc_tick(div_q[ictu_pkg::GRP_FREE],
						pre_q[ictu_pkg::GRP_FREE]);
					pre_d[ictu_pkg::GRP_FREE] = ps.cnt;
					free_cnt_d = free_cnt_q + DW'(ps.step);
				end
				if (up_run_q != '0) begin
					ps = ictu_pkg::presc_tick(div_q[ictu_pkg::GRP_UP],
						pre_q[ictu_pkg::GRP_UP]);
					pre_d[ictu_pkg::GRP_UP] = ps.cnt;
					for (int m = 0; m < UC; m++) begin
						if (up_run_q[m] && ps.step) begin
							cnt         = up_cnt_q[m] + 1'b1;
							up_cnt_d[m] = cnt;
							for (int i = 0; i < CC; i++) begin
								if (cmp_val_q[m][i] == cnt) begin
									if ((!gate_q || cmp_flag_d == '0) &&
											cmp_en_q[ictu_pkg::CMP_SLOT*m+i]) begin
										rsp_d.compare_irq[ictu_pkg::CMP_SLOT*m+i] = 1'b1;
									end
									cmp_flag_d[ictu_pkg::CMP_SLOT*m+i] = 1'b1;
								end
							end
						end
					end
				end
			end
			ictu_pkg::ACT_READ: begin
				case (idx)
					ictu_pkg::REG_IVL_RUN:   rsp_d.read_data = DW'(ivl_run_q);
					ictu_pkg::REG_IVL_EN:    rsp_d.read_data = DW'(ivl_en_q);
					ictu_pkg::REG_IVL_FLAGS: rsp_d.read_data = DW'(ivl_flag_q);
					ictu_pkg::REG_IVL_DIV:   rsp_d.read_data = DW'(div_q[ictu_pkg::GRP_IVL]);
					ictu_pkg::REG_FREE_RUN:  rsp_d.read_data = DW'(free_run_q);
					ictu_pkg::REG_FREE_DIV:  rsp_d.read_data = DW'(div_q[ictu_pkg::GRP_FREE]);
					ictu_pkg::REG_UP_RUN:    rsp_d.read_data = DW'(up_run_q);
					ictu_pkg::REG_CMP_EN:    rsp_d.read_data = ictu_pkg::cmp_to_reg(cmp_en_q);
					ictu_pkg::REG_CMP_FLAGS: begin
						rsp_d.read_data = ictu_pkg::cmp_to_reg(cmp_flag_q);
					end
					ictu_pkg::REG_UP_DIV:    rsp_d.read_data = DW'(div_q[ictu_pkg::GRP_UP]);
					ictu_pkg::REG_TRIG:      rsp_d.read_data = DW'(trig_q);
					ictu_pkg::REG_GATE:      rsp_d.read_data = DW'(gate_q);
					ictu_pkg::REG_FREE_CNT:  rsp_d.read_data = free_cnt_q;
					default: begin
						for (int m = 0; m < IC; m++) begin
							if (idx == 6'(ictu_pkg::REG_IVL_CNT0 + 2*m)) begin
								rsp_d.read_data = ivl_cnt_q[m];
							end
							if (idx == 6'(ictu_pkg::REG_IVL_CNT0 + 2*m + 1)) begin
								rsp_d.read_data = ivl_rld_q[m];
							end
						end
						for (int m = 0; m < UC; m++) begin
							if (idx == 6'(ictu_pkg::REG_UP_CNT0 + m)) begin
								rsp_d.read_data = up_cnt_q[m];
							end
							for (int i = 0; i < CC; i++) begin
								if (idx == 6'(ictu_pkg::REG_CMP_VAL0 +
										ictu_pkg::CMP_SLOT*m + i)) begin
									rsp_d.read_data = cmp_val_q[m][i];
								end
							end
						end
					end
				endcase
			end
			ictu_pkg::ACT_WRITE: begin
				case (idx)
					ictu_pkg::REG_IVL_START: begin
						for (int m = 0; m < IC; m++) begin
							if (v[m]) begin
								ivl_cnt_d[m] = ivl_rld_q[m];
								ivl_run_d[m] = 1'b1;
							end
						end
					end
					ictu_pkg::REG_IVL_RESTART: begin
						for (int m = 0; m < IC; m++) begin
							if (v[m] && ivl_run_q[m]) begin
								ivl_cnt_d[m] = ivl_rld_q[m];
							end
						end
					end
					ictu_pkg::REG_IVL_STOP: ivl_run_d = ivl_run_q & ~v[IC-1:0];
					ictu_pkg::REG_IVL_EN: begin
						ivl_en_d           = v[IC-1:0];
						rsp_d.interval_irq = |(ivl_flag_q & v[IC-1:0]);
					end
					ictu_pkg::REG_IVL_FLAGS: ivl_flag_d = ivl_flag_q & v[IC-1:0];
					ictu_pkg::REG_IVL_DIV: begin
						div_d[ictu_pkg::GRP_IVL] = v[VW-1:0];
						pre_d[ictu_pkg::GRP_IVL] = '0;
					end
					ictu_pkg::REG_FREE_START: begin
						if (v[0]) begin
							free_cnt_d = '0;
							free_run_d = 1'b1;
						end
					end
					ictu_pkg::REG_FREE_RESTART: begin
						if (v[0] && free_run_q) begin
							free_cnt_d = '0;
						end
					end
					ictu_pkg::REG_FREE_STOP: begin
						if (v[0]) begin
							free_run_d = 1'b0;
						end
					end
					ictu_pkg::REG_FREE_DIV: begin
						div_d[ictu_pkg::GRP_FREE] = v[VW-1:0];
						pre_d[ictu_pkg::GRP_FREE] = '0;
					end
					ictu_pkg::REG_UP_START: begin
						for (int m = 0; m < UC; m++) begin
							if (v[m]) begin
								up_cnt_d[m] = '0;
								up_run_d[m] = 1'b1;
							end
						end
					end
					ictu_pkg::REG_UP_RESTART: begin
						for (int m = 0; m < UC; m++) begin
							if (v[m] && up_run_q[m]) begin
								up_cnt_d[m] = '0;
							end
						end
					end
					ictu_pkg::REG_UP_STOP: up_run_d = up_run_q & ~v[UC-1:0];
					ictu_pkg::REG_CMP_EN: cmp_en_d = {v[11:8], v[3:0]};
					ictu_pkg::REG_CMP_FLAGS: cmp_flag_d = cmp_flag_q & {v[11:8], v[3:0]};
					ictu_pkg::REG_UP_DIV: begin
						div_d[ictu_pkg::GRP_UP] = v[VW-1:0];
						pre_d[ictu_pkg::GRP_UP] = '0;
					end
					ictu_pkg::REG_TRIG: trig_d = v[ictu_pkg::TRIG_W-1:0];
					ictu_pkg::REG_GATE: gate_d = v[0];
					ictu_pkg::REG_FREE_CNT: free_cnt_d = v;
					default: begin
						for (int m = 0; m < IC; m++) begin
							if (idx == 6'(ictu_pkg::REG_IVL_CNT0 + 2*m)) begin
								ivl_cnt_d[m] = v;
							end
							if (idx == 6'(ictu_pkg::REG_IVL_CNT0 + 2*m + 1)) begin
								ivl_rld_d[m] = v;
							end
						end
						for (int m = 0; m < UC; m++) begin
							if (idx == 6'(ictu_pkg::REG_UP_CNT0 + m)) begin
								up_cnt_d[m] = v;
							end
							for (int i = 0; i < CC; i++) begin
								if (idx == 6'(ictu_pkg::REG_CMP_VAL0 +
										ictu_pkg::CMP_SLOT*m + i)) begin
									cmp_val_d[m][i] = v;
								end
							end
						end
					end
				endcase
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	a_read_no_irq: assert property (@(posedge clk) disable iff (!arst_n)
		proc && req_s1.action == ictu_pkg::ACT_READ
		|=> !rsp_q.interval_irq && rsp_q.compare_irq == '0)
		else $error("A read item raised an interrupt.");

	a_cmp_irq_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		proc |=> (rsp_q.compare_irq & ~$past(cmp_en_q)) == '0)
		else $error("A compare interrupt was raised without its enable bit.");

	a_gate_single: assert property (@(posedge clk) disable iff (!arst_n)
		proc && gate_q |=> $countones(rsp_q.compare_irq) <= 1)
		else $error("More than one compare interrupt was raised in gating mode.");

	a_cmp_irq_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		proc |=> (rsp_q.compare_irq & ~cmp_flag_q) == '0)
		else $error("A compare interrupt was raised without its flag being set.");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(req_s1))
		else $error("A waiting item was lost or changed in the input register.");

endmodule
